FILE: rtl/core/mm4_pkg.sv
package mm4_pkg;

  localparam int WORD_W         = 32;
  localparam int DIM            = 4;
  localparam int ROW_W          = $clog2(DIM);
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_MUL  = 1'b1
  } func_t;

  typedef struct packed {
    func_t                    func;
    logic [ROW_W-1:0]         row_index;
    logic signed [WORD_W-1:0] elem0;
    logic signed [WORD_W-1:0] elem1;
    logic signed [WORD_W-1:0] elem2;
    logic signed [WORD_W-1:0] elem3;
  } cmd_t;

  typedef struct packed {
    logic [ROW_W-1:0]         out_row;
    logic signed [WORD_W-1:0] prod0;
    logic signed [WORD_W-1:0] prod1;
    logic signed [WORD_W-1:0] prod2;
    logic signed [WORD_W-1:0] prod3;
  } res_t;

  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
  } adv_t;

endpackage

FILE: rtl/core/mm4_mat.sv
module mm4_mat #(
  parameter int DATA_WIDTH = mm4_pkg::DATA_WIDTH_DEF
) (
  input  logic                                                  clk,
  input  logic                                                  we,
  input  logic [mm4_pkg::ROW_W-1:0]                             row,
  input  logic [mm4_pkg::DIM-1:0][DATA_WIDTH-1:0]               data,
  output logic [mm4_pkg::DIM-1:0][mm4_pkg::DIM-1:0][DATA_WIDTH-1:0] mat
);
  import mm4_pkg::*;

  always_ff @(posedge clk) begin
    if (we) begin
      mat[row] <= data;
    end
  end

endmodule

FILE: rtl/core/mm4_lane.sv
module mm4_lane #(
  parameter int DATA_WIDTH = mm4_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = mm4_pkg::FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  mm4_pkg::adv_t                           adv,
  input  logic [mm4_pkg::DIM-1:0][DATA_WIDTH-1:0] a,
  input  logic [mm4_pkg::DIM-1:0][DATA_WIDTH-1:0] b,
  output logic [mm4_pkg::WORD_W-1:0]              prod
);
  import mm4_pkg::*;

  localparam int PW = 2 * DATA_WIDTH;
  localparam int SW = PW + 2;
  localparam logic signed [SW-1:0] MAXV = {{(SW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] MINV = {{(SW-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

  logic signed [DATA_WIDTH-1:0] as [DIM];
  logic signed [DATA_WIDTH-1:0] bs [DIM];
  logic signed [PW-1:0]         p  [DIM];
  logic signed [PW:0]           s01;
  logic signed [PW:0]           s23;
  logic signed [SW-1:0]         sum;
  logic signed [SW-1:0]         shifted;
  logic signed [DATA_WIDTH-1:0] sat;

  always_comb begin
    for (int k = 0; k < DIM; k++) begin
      as[k] = a[k];
      bs[k] = b[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv.ld1) begin
      for (int k = 0; k < DIM; k++) begin
        p[k] <= as[k] * bs[k];
      end
    end
    if (adv.ld2) begin
      s01 <= (PW+1)'(p[0]) + (PW+1)'(p[1]);
      s23 <= (PW+1)'(p[2]) + (PW+1)'(p[3]);
    end
    if (adv.ld3) begin
      sum <= SW'(s01) + SW'(s23);
    end
    if (adv.ld4) begin
      prod <= WORD_W'(sat);
    end
  end

  always_comb begin
    shifted = sum >>> FRAC_BITS;
    if (shifted > MAXV) begin
      sat = MAXV[DATA_WIDTH-1:0];
    end else if (shifted < MINV) begin
      sat = MINV[DATA_WIDTH-1:0];
    end else begin
      sat = shifted[DATA_WIDTH-1:0];
    end
  end

endmodule

FILE: rtl/core/matrix_multiply_4x4_top.sv
// 4x4 fixed-point matrix product, one row per request.
// Channels: cmd (cmd_valid, cmd_stall, cmd) carries requests in; res (res_valid,
// res_stall, res) carries product rows out. A transfer happens on a rising
// edge with valid high and stall low.
// A load request (func FUNC_LOAD) writes its four words into row row_index of
// the stored right matrix at the edge it is accepted and gives no result.
// A multiply request (func FUNC_MUL) gives one product row, tagged with its
// row_index, using the stored matrix as it stands when the request is accepted.
// Pipeline: multipliers, two adder levels, then shift and saturate, each stage
// registered before res_valid. Throughput: one request per cycle while cmd_stall
// is low, set by four column lanes of four multipliers each working in parallel.
// When res_stall is high the pipeline compresses its bubbles and holds the
// result; cmd_stall rises only once all four stages hold results.
// Reset clears all valid bits; the stored matrix is undefined until loaded.
module matrix_multiply_4x4_top #(
  parameter int DATA_WIDTH = mm4_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = mm4_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  mm4_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_stall,
  output mm4_pkg::res_t res
);
  import mm4_pkg::*;

  adv_t                                     adv;
  logic                                     v1;
  logic                                     v2;
  logic                                     v3;
  logic [ROW_W-1:0]                         row1;
  logic [ROW_W-1:0]                         row2;
  logic [ROW_W-1:0]                         row3;
  logic [ROW_W-1:0]                         row4;
  logic                                     load_we;
  logic [DIM-1:0][DATA_WIDTH-1:0]           a;
  logic [DIM-1:0][DIM-1:0][DATA_WIDTH-1:0]  mat;
  logic [DIM-1:0][DIM-1:0][DATA_WIDTH-1:0]  col;
  logic [DIM-1:0][WORD_W-1:0]               lane_prod;

  always_comb begin
    adv.ld4   = !res_valid || !res_stall;
    adv.ld3   = !v3 || adv.ld4;
    adv.ld2   = !v2 || adv.ld3;
    adv.ld1   = !v1 || adv.ld2;
    cmd_stall = !adv.ld1;
    load_we   = cmd_valid && adv.ld1 && (cmd.func == FUNC_LOAD);
    a[0]      = cmd.elem0[DATA_WIDTH-1:0];
    a[1]      = cmd.elem1[DATA_WIDTH-1:0];
    a[2]      = cmd.elem2[DATA_WIDTH-1:0];
    a[3]      = cmd.elem3[DATA_WIDTH-1:0];
    for (int j = 0; j < DIM; j++) begin
      for (int k = 0; k < DIM; k++) begin
        col[j][k] = mat[k][j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (adv.ld1) v1 <= cmd_valid && (cmd.func == FUNC_MUL);
      if (adv.ld2) v2 <= v1;
      if (adv.ld3) v3 <= v2;
      if (adv.ld4) res_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.ld1) row1 <= cmd.row_index;
    if (adv.ld2) row2 <= row1;
    if (adv.ld3) row3 <= row2;
    if (adv.ld4) row4 <= row3;
  end

  mm4_mat #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_mat (
    .clk (clk),
    .we  (load_we),
    .row (cmd.row_index),
    .data(a),
    .mat (mat)
  );

  for (genvar j = 0; j < DIM; j++) begin : g_lane
    mm4_lane #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk (clk),
      .adv (adv),
      .a   (a),
      .b   (col[j]),
      .prod(lane_prod[j])
    );
  end

  always_comb begin
    res.out_row = row4;
    res.prod0   = lane_prod[0];
    res.prod1   = lane_prod[1];
    res.prod2   = lane_prod[2];
    res.prod3   = lane_prod[3];
  end

endmodule

FILE: rtl/core/mm4_check.sv
module mm4_check (
  input logic          clk,
  input logic          rst,
  input logic          cmd_valid,
  input logic          cmd_stall,
  input mm4_pkg::cmd_t cmd,
  input logic          res_valid,
  input logic          res_stall,
  input mm4_pkg::res_t res
);
  import mm4_pkg::*;

  logic mul_acc;

  assign mul_acc = cmd_valid && !cmd_stall && (cmd.func == FUNC_MUL);

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled result changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> res_valid && res_stall)
    else $error("request stalled without a stalled result");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    mul_acc && !res_stall ##1 !res_stall ##1 !res_stall ##1 !res_stall |=> res_valid)
    else $error("multiply result missing after four free cycles");

endmodule

bind matrix_multiply_4x4_top mm4_check u_check (.*);
